/* rtl/sem_pkg.sv */
// ----------------------------------------------------------------------------
// sem_pkg
// shared types and constants of the segment endpoint median block
// ----------------------------------------------------------------------------
package sem_pkg;

    localparam int COORD_W    = 12;
    localparam int NUM_COORDS = 4;

    typedef logic [COORD_W-1:0] t_coord;

    typedef enum logic {
        S_COLLECT,
        S_DRAIN
    } t_state;

    // control handed from the sequencer to the merging stage
    typedef struct packed {
        logic load;        // take the lane heads into the result register
        logic odd;         // stored count is odd
        logic empty;       // nothing stored
        logic overflowed;  // segments were dropped in this set
    } t_merge_ctrl;

endpackage

/* rtl/sem_if.sv */
// ----------------------------------------------------------------------------
// sem_seg_if / sem_med_if
// valid/ready channels for segment beats and median result beats
// ----------------------------------------------------------------------------
interface sem_seg_if;
    logic           valid;
    logic           ready;
    sem_pkg::t_coord start_x;
    sem_pkg::t_coord start_y;
    sem_pkg::t_coord end_x;
    sem_pkg::t_coord end_y;
    logic           is_final;

    modport source (output valid, start_x, start_y, end_x, end_y, is_final, input ready);
    modport sink   (input valid, start_x, start_y, end_x, end_y, is_final, output ready);
endinterface

interface sem_med_if;
    logic           valid;
    logic           ready;
    sem_pkg::t_coord median_start_x;
    sem_pkg::t_coord median_start_y;
    sem_pkg::t_coord median_end_x;
    sem_pkg::t_coord median_end_y;
    logic           set_empty;
    logic           set_overflowed;

    modport source (output valid, median_start_x, median_start_y, median_end_x,
                    median_end_y, set_empty, set_overflowed, input ready);
    modport sink   (input valid, median_start_x, median_start_y, median_end_x,
                    median_end_y, set_empty, set_overflowed, output ready);
endinterface

/* rtl/sem_lane.sv */
// ----------------------------------------------------------------------------
// sem_lane
// sorted insertion chain for one coordinate, drained towards cell 0
// ----------------------------------------------------------------------------
module sem_lane #(
    parameter int DEPTH = 64,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic            i_clk,
    input  logic            i_ins,
    input  logic            i_shift,
    input  logic [CNT_W-1:0] i_count,
    input  sem_pkg::t_coord i_value,
    output sem_pkg::t_coord o_head0,
    output sem_pkg::t_coord o_head1
);

    localparam int HI = (DEPTH > 1) ? 1 : 0;

    sem_pkg::t_coord r_cell [DEPTH];
    sem_pkg::t_coord n_cell [DEPTH];

    // each cell compares against the new value only; the chain shifts open
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            logic prev_gt;
            logic cur_gt;
            prev_gt = 1'b0;
            if (i > 0) begin
                prev_gt = (CNT_W'(i - 1) < i_count) && (r_cell[i-1] > i_value);
            end
            cur_gt = (CNT_W'(i) >= i_count) || (r_cell[i] > i_value);
            if (i_shift) begin
                n_cell[i] = (i < DEPTH - 1) ? r_cell[(i < DEPTH - 1) ? i + 1 : i] : r_cell[i];
            end else if (!i_ins) begin
                n_cell[i] = r_cell[i];
            end else if (prev_gt) begin
                n_cell[i] = r_cell[(i > 0) ? i - 1 : 0];
            end else if (cur_gt) begin
                n_cell[i] = i_value;
            end else begin
                n_cell[i] = r_cell[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cell <= n_cell;
    end

    assign o_head0 = r_cell[0];
    assign o_head1 = r_cell[HI];

endmodule

/* rtl/sem_merge.sv */
// ----------------------------------------------------------------------------
// sem_merge
// combines the lane heads into medians and holds the result beat
// ----------------------------------------------------------------------------
module sem_merge (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sem_pkg::t_merge_ctrl i_ctrl,
    input  sem_pkg::t_coord      i_head0 [sem_pkg::NUM_COORDS],
    input  sem_pkg::t_coord      i_head1 [sem_pkg::NUM_COORDS],
    sem_med_if.source            o_med
);

    sem_pkg::t_coord w_med [sem_pkg::NUM_COORDS];
    logic            r_valid;

    always_comb begin
        for (int c = 0; c < sem_pkg::NUM_COORDS; c++) begin
            logic [sem_pkg::COORD_W:0] sum;
            sum = {1'b0, i_head0[c]} + {1'b0, i_head1[c]};
            if (i_ctrl.empty) begin
                w_med[c] = '0;
            end else if (i_ctrl.odd) begin
                w_med[c] = i_head0[c];
            end else begin
                w_med[c] = sum[sem_pkg::COORD_W:1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.load) begin
            r_valid <= 1'b1;
        end else if (o_med.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            o_med.median_start_x <= w_med[0];
            o_med.median_start_y <= w_med[1];
            o_med.median_end_x   <= w_med[2];
            o_med.median_end_y   <= w_med[3];
            o_med.set_empty      <= i_ctrl.empty;
            o_med.set_overflowed <= i_ctrl.overflowed;
        end
    end

    assign o_med.valid = r_valid;

endmodule

/* rtl/segment_endpoint_median.sv */
// ----------------------------------------------------------------------------
// segment_endpoint_median
// per-coordinate median over a set of line segments
// ----------------------------------------------------------------------------
// Segment beats are taken one per cycle while the block collects; each
// beat inserts its four coordinates into four sorted chains (one lane per
// coordinate) in the same cycle. The beat marked final is inserted as
// well, after which the chains drain towards their head until the middle
// entry (odd count) or the lower middle entry (even count) is there; then
// the lane heads are merged into the medians and the result beat is
// registered. The segment side is stalled from the final beat until the
// result register is loaded. A result still waiting in the register holds
// off the load and so lengthens the stall. A waiting result does not
// stall the segments of the next set. Segments beyond MAX_SEGMENTS are
// dropped and flagged in set_overflowed.
// ----------------------------------------------------------------------------
module segment_endpoint_median #(
    parameter int MAX_SEGMENTS = 64
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    sem_seg_if.sink  i_seg,
    sem_med_if.source o_med
);

    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
    localparam int SH_W  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

    sem_pkg::t_state      r_state;
    sem_pkg::t_state      n_state;
    logic [CNT_W-1:0]     r_count;
    logic [SH_W-1:0]      r_shift;
    logic                 r_ovf;

    logic                 w_accept;
    logic                 w_ins;
    logic                 w_shift;
    logic                 w_load;
    logic [CNT_W-1:0]     w_cnt_upd;
    logic [CNT_W-1:0]     w_half;
    logic [SH_W-1:0]      w_shift_len;
    sem_pkg::t_merge_ctrl w_ctrl;

    sem_pkg::t_coord      w_value [sem_pkg::NUM_COORDS];
    sem_pkg::t_coord      w_head0 [sem_pkg::NUM_COORDS];
    sem_pkg::t_coord      w_head1 [sem_pkg::NUM_COORDS];

    // a beat counts once accepted; it is stored only while there is room
    assign w_accept = i_seg.valid && i_seg.ready;
    assign w_ins    = w_accept && (r_count != CNT_W'(MAX_SEGMENTS));

    // count after this beat, and the drain length that brings the middle
    // entry (odd count) or the lower middle entry (even count) to the head
    assign w_cnt_upd   = w_ins ? (r_count + CNT_W'(1)) : r_count;
    assign w_half      = w_cnt_upd >> 1;
    assign w_shift_len = w_cnt_upd[0] ? SH_W'(w_half)
                       : ((w_half == '0) ? '0 : SH_W'(w_half - CNT_W'(1)));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sem_pkg::S_COLLECT: begin
                if (w_accept && i_seg.is_final) begin
                    n_state = sem_pkg::S_DRAIN;
                end
            end
            sem_pkg::S_DRAIN: begin
                if (w_load) begin
                    n_state = sem_pkg::S_COLLECT;
                end
            end
            default: n_state = sem_pkg::S_COLLECT;
        endcase
    end

    // state outputs
    always_comb begin
        i_seg.ready = 1'b0;
        w_shift     = 1'b0;
        w_load      = 1'b0;
        case (r_state)
            sem_pkg::S_COLLECT: begin
                i_seg.ready = 1'b1;
            end
            sem_pkg::S_DRAIN: begin
                w_shift = (r_shift != '0);
                // load only once the result register is free
                w_load  = (r_shift == '0) && (!o_med.valid || o_med.ready);
            end
            default: begin
                i_seg.ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sem_pkg::S_COLLECT;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_shift <= '0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
            end else begin
                r_count <= w_cnt_upd;
                if (w_accept && !w_ins) begin
                    r_ovf <= 1'b1;
                end
            end
            if (w_accept && i_seg.is_final) begin
                r_shift <= w_shift_len;
            end else if (w_shift) begin
                r_shift <= r_shift - SH_W'(1);
            end
        end
    end

    assign w_value[0] = i_seg.start_x;
    assign w_value[1] = i_seg.start_y;
    assign w_value[2] = i_seg.end_x;
    assign w_value[3] = i_seg.end_y;

    // one sorted chain per coordinate
    for (genvar c = 0; c < sem_pkg::NUM_COORDS; c++) begin : g_lane
        sem_lane #(
            .DEPTH (MAX_SEGMENTS),
            .CNT_W (CNT_W)
        ) u_lane (
            .i_clk   (i_clk),
            .i_ins   (w_ins),
            .i_shift (w_shift),
            .i_count (r_count),
            .i_value (w_value[c]),
            .o_head0 (w_head0[c]),
            .o_head1 (w_head1[c])
        );
    end

    assign w_ctrl.load       = w_load;
    assign w_ctrl.odd        = r_count[0];
    assign w_ctrl.empty      = (r_count == '0);
    assign w_ctrl.overflowed = r_ovf;

    sem_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .i_head0 (w_head0),
        .i_head1 (w_head1),
        .o_med   (o_med)
    );

endmodule

/* tb/segment_endpoint_median_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// segment_endpoint_median_test
// self-checking bench for the per-coordinate segment median block
// ----------------------------------------------------------------------------
// Segment beats are sent through the valid/ready segment channel. Every
// accepted beat is also fed into a behavioural copy of the four sorted
// chains, which queues the expected medians whenever a final beat goes in.
// A monitor compares each accepted median beat field by field against the
// oldest queued expectation. Directed sets cover the coordinate extremes,
// odd and even counts, truncation of the middle mean, duplicates and a full
// store with dropped segments; random sets of mostly small size follow,
// with random idling on both channels and one long receiver hold-off that
// backs the block up into its segment input.
// ----------------------------------------------------------------------------
module segment_endpoint_median_test;

    localparam int MAX_SEGMENTS = 64;
    localparam int ITEM_TARGET  = 1450;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 64;   // longest drain of the chains plus margin
    localparam int HOLD_CYCLES  = 400;  // long receiver hold-off
    localparam int MAX_GAP      = 13;
    localparam int REPORT_LIMIT = 10;

    // coordinate styles for generated sets
    typedef enum int {
        STYLE_SPREAD,
        STYLE_CLUSTER,
        STYLE_EXTREME
    } t_coord_style;

    typedef struct packed {
        sem_pkg::t_coord start_x;
        sem_pkg::t_coord start_y;
        sem_pkg::t_coord end_x;
        sem_pkg::t_coord end_y;
        logic            is_final;
    } t_seg_beat;

    typedef struct packed {
        sem_pkg::t_coord median_start_x;
        sem_pkg::t_coord median_start_y;
        sem_pkg::t_coord median_end_x;
        sem_pkg::t_coord median_end_y;
        logic            set_empty;
        logic            set_overflowed;
    } t_med_beat;

    logic i_clk;
    logic i_rst_n;

    sem_seg_if seg_ch ();
    sem_med_if med_ch ();

    segment_endpoint_median #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_seg   (seg_ch),
        .o_med   (med_ch)
    );

    // expected medians, oldest first
    t_med_beat pending_medians [$];

    // behavioural copy of the sorted chains
    sem_pkg::t_coord chain [sem_pkg::NUM_COORDS][MAX_SEGMENTS];
    int unsigned     chain_len;
    bit              set_dropped;

    int fail_count;
    int segs_sent;
    int cycle_count;

    // idling controls, changed by the tests
    int src_gap_max;
    int sink_gap_max;
    int hold_cycles;

    // ------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // median predictor: insert the beat into the chains, and on a final
    // beat queue the medians of the set and start a fresh one
    // ------------------------------------------------------------------
    function automatic void absorb_segment(input t_seg_beat b);
        sem_pkg::t_coord          v   [sem_pkg::NUM_COORDS];
        sem_pkg::t_coord          mid [sem_pkg::NUM_COORDS];
        logic [sem_pkg::COORD_W:0] pair_sum;
        int                       pos;
        int                       half;
        t_med_beat                m;
        v[0] = b.start_x;
        v[1] = b.start_y;
        v[2] = b.end_x;
        v[3] = b.end_y;
        if (chain_len < MAX_SEGMENTS) begin
            for (int c = 0; c < sem_pkg::NUM_COORDS; c++) begin
                pos = chain_len;
                while (pos > 0 && chain[c][pos-1] > v[c]) begin
                    chain[c][pos] = chain[c][pos-1];
                    pos--;
                end
                chain[c][pos] = v[c];
            end
            chain_len++;
        end else begin
            // store full: segment is dropped, only the flag remembers it
            set_dropped = 1'b1;
        end
        if (b.is_final) begin
            half = chain_len / 2;
            for (int c = 0; c < sem_pkg::NUM_COORDS; c++) begin
                if (chain_len == 0) begin
                    mid[c] = '0;
                end else if (chain_len % 2 == 0) begin
                    // even count: mean of the two middle entries, rounded down
                    pair_sum = {1'b0, chain[c][half]} + {1'b0, chain[c][half-1]};
                    mid[c]   = pair_sum[sem_pkg::COORD_W:1];
                end else begin
                    mid[c] = chain[c][half];
                end
            end
            m.median_start_x = mid[0];
            m.median_start_y = mid[1];
            m.median_end_x   = mid[2];
            m.median_end_y   = mid[3];
            m.set_empty      = (chain_len == 0);
            m.set_overflowed = set_dropped;
            pending_medians  = {pending_medians, m};
            chain_len   = 0;
            set_dropped = 1'b0;
        end
    endfunction

    function automatic t_seg_beat make_seg(input int sx, input int sy, input int ex,
                                           input int ey, input bit fin);
        t_seg_beat b;
        b.start_x  = sem_pkg::t_coord'(sx);
        b.start_y  = sem_pkg::t_coord'(sy);
        b.end_x    = sem_pkg::t_coord'(ex);
        b.end_y    = sem_pkg::t_coord'(ey);
        b.is_final = fin;
        return b;
    endfunction

    function automatic sem_pkg::t_coord pick_coord(input t_coord_style style,
                                                   input int base);
        case (style)
            STYLE_CLUSTER: return sem_pkg::t_coord'(base + $urandom_range(3, 0));
            STYLE_EXTREME: return ($urandom_range(1, 0) == 1) ? sem_pkg::t_coord'(4095)
                                                              : sem_pkg::t_coord'(0);
            default:       return sem_pkg::t_coord'($urandom_range(4095, 0));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // segment source: optional gap, then hold the beat until taken
    // ------------------------------------------------------------------
    task automatic send_segment(input t_seg_beat b);
        int gap;
        gap = $urandom_range(src_gap_max, 0);
        if (gap > 0) begin
            seg_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        seg_ch.valid    <= 1'b1;
        seg_ch.start_x  <= b.start_x;
        seg_ch.start_y  <= b.start_y;
        seg_ch.end_x    <= b.end_x;
        seg_ch.end_y    <= b.end_y;
        seg_ch.is_final <= b.is_final;
        do @(posedge i_clk); while (!seg_ch.ready);
        absorb_segment(b);
        segs_sent++;
    endtask

    // one whole set of n segments, the last one marked final
    task automatic send_set(input int n, input t_coord_style style);
        int base;
        base = $urandom_range(4092, 0);
        for (int i = 0; i < n; i++) begin
            send_segment(make_seg(pick_coord(style, base), pick_coord(style, base),
                                  pick_coord(style, base), pick_coord(style, base),
                                  i == n - 1));
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // single-segment sets at the coordinate extremes
    task automatic test_single_extremes();
        send_segment(make_seg(0, 4095, 0, 4095, 1'b1));
        send_segment(make_seg(4095, 0, 4095, 0, 1'b1));
        send_segment(make_seg(2048, 2047, 1, 4094, 1'b1));
    endtask

    // even counts: middle mean truncated, odd sums included
    task automatic test_even_mean();
        send_segment(make_seg(4095, 0, 1, 4095, 1'b0));
        send_segment(make_seg(4094, 1, 0, 4095, 1'b1));
        send_segment(make_seg(10, 3, 4095, 0, 1'b0));
        send_segment(make_seg(20, 2, 0, 4095, 1'b0));
        send_segment(make_seg(30, 1, 4095, 0, 1'b0));
        send_segment(make_seg(40, 0, 0, 4095, 1'b1));
    endtask

    // odd counts in descending, ascending and repeated order
    task automatic test_odd_order();
        for (int i = 0; i < 5; i++) begin
            send_segment(make_seg(4095 - i * 1000, i * 1000, 4095 - i, i, i == 4));
        end
        for (int i = 0; i < 3; i++) begin
            send_segment(make_seg(7, 7, 4095, 0, i == 2));
        end
        send_segment(make_seg(100, 5, 3000, 0, 1'b0));
        send_segment(make_seg(100, 5, 3000, 4095, 1'b0));
        send_segment(make_seg(9, 4095, 0, 4095, 1'b1));
    endtask

    // exactly a full store, then two sets with dropped segments, then a
    // short set to show the flag and count are cleared at end of set
    task automatic test_store_full();
        send_set(MAX_SEGMENTS, STYLE_SPREAD);
        send_set(MAX_SEGMENTS + 6, STYLE_SPREAD);
        send_set(MAX_SEGMENTS + 1, STYLE_EXTREME);
        send_set(2, STYLE_SPREAD);
    endtask

    // receiver holds off for a long stretch while sets keep coming,
    // so results pile up and the segment input backs up
    task automatic test_backpressure();
        src_gap_max = 0;
        hold_cycles = HOLD_CYCLES;
        for (int i = 0; i < 12; i++) begin
            send_set($urandom_range(5, 1), STYLE_SPREAD);
        end
        src_gap_max = MAX_GAP;
    endtask

    // random sets, mostly small, with the idling changed now and then
    task automatic test_random_sets();
        int roll;
        int size;
        int sets_done;
        sets_done = 0;
        while (segs_sent < ITEM_TARGET) begin
            if (sets_done % 8 == 0) begin
                case ($urandom_range(2, 0))
                    0:       src_gap_max = 0;
                    1:       src_gap_max = 2;
                    default: src_gap_max = MAX_GAP;
                endcase
                case ($urandom_range(2, 0))
                    0:       sink_gap_max = 0;
                    1:       sink_gap_max = 2;
                    default: sink_gap_max = MAX_GAP;
                endcase
            end
            roll = $urandom_range(99, 0);
            if (roll < 70)      size = $urandom_range(8, 1);
            else if (roll < 90) size = $urandom_range(40, 9);
            else if (roll < 97) size = $urandom_range(MAX_SEGMENTS, 41);
            else                size = $urandom_range(MAX_SEGMENTS + 16, MAX_SEGMENTS + 1);
            send_set(size, t_coord_style'($urandom_range(2, 0)));
            sets_done++;
        end
    endtask

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    initial begin
        i_rst_n         <= 1'b0;
        seg_ch.valid    <= 1'b0;
        seg_ch.start_x  <= '0;
        seg_ch.start_y  <= '0;
        seg_ch.end_x    <= '0;
        seg_ch.end_y    <= '0;
        seg_ch.is_final <= 1'b0;
        chain_len    = 0;
        set_dropped  = 1'b0;
        fail_count   = 0;
        segs_sent    = 0;
        src_gap_max  = MAX_GAP;
        sink_gap_max = MAX_GAP;
        hold_cycles  = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_single_extremes();
        test_even_mean();
        test_odd_order();
        test_store_full();
        test_backpressure();
        test_random_sets();

        // stimulus done: go idle, let the results drain, then settle
        seg_ch.valid <= 1'b0;
        while (pending_medians.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending_medians.size() == 0) begin
            $display("segment_endpoint_median_test passed");
        end else begin
            $display("segment_endpoint_median_test failed");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // median sink: random ready gaps per beat, long hold-off on request
    // ------------------------------------------------------------------
    initial begin
        int gap;
        med_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            gap = $urandom_range(sink_gap_max, 0);
            if (hold_cycles > 0) begin
                gap         = hold_cycles;
                hold_cycles = 0;
            end
            if (gap > 0) begin
                med_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            med_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!med_ch.valid);
        end
    end

    // ------------------------------------------------------------------
    // result monitor: one check per accepted median beat
    // ------------------------------------------------------------------
    function automatic void note_fault(input string what, input int want, input int got);
        fail_count++;
        if (fail_count <= REPORT_LIMIT) begin
            $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_med_beat want;
        if (i_rst_n && med_ch.valid && med_ch.ready) begin
            if (pending_medians.size() == 0) begin
                note_fault("median beat with nothing expected", 0, 1);
            end else begin
                want = pending_medians.pop_front();
                if (med_ch.median_start_x !== want.median_start_x)
                    note_fault("median_start_x", want.median_start_x, med_ch.median_start_x);
                if (med_ch.median_start_y !== want.median_start_y)
                    note_fault("median_start_y", want.median_start_y, med_ch.median_start_y);
                if (med_ch.median_end_x !== want.median_end_x)
                    note_fault("median_end_x", want.median_end_x, med_ch.median_end_x);
                if (med_ch.median_end_y !== want.median_end_y)
                    note_fault("median_end_y", want.median_end_y, med_ch.median_end_y);
                if (med_ch.set_empty !== want.set_empty)
                    note_fault("set_empty", want.set_empty, med_ch.set_empty);
                if (med_ch.set_overflowed !== want.set_overflowed)
                    note_fault("set_overflowed", want.set_overflowed, med_ch.set_overflowed);
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog
    // ------------------------------------------------------------------
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("segment_endpoint_median_test failed");
        $finish;
    end

endmodule
